FILE: rtl/wfts_pkg.sv
// ----------------------------------------------------------------------------
// wfts_pkg
// shared constants and types for the frame interval statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package wfts_pkg;

    localparam int          DefaultDepth = 128;
    localparam int          FracW        = 17;
    localparam logic [16:0] FracReset    = 17'd62259;
    localparam int          FracShift    = 16;
    localparam logic [27:0] FpsNumerator = 28'd256000000;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_MEAN  = 7'b0000100,
        S_RANK  = 7'b0001000,
        S_FPS   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    // request and reply between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [42:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [42:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/wfts_div.sv
// ----------------------------------------------------------------------------
// wfts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wfts_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wfts_pkg::t_div_req i_req,
    output wfts_pkg::t_div_rsp     o_rsp
);
    import wfts_pkg::*;

    logic [42:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_rem[31:0], r_quo[42]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd43;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!w_trial[33]) begin
                    r_rem <= w_trial[32:0];
                    r_quo <= {r_quo[41:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[41:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

FILE: rtl/window_frame_time_stats.sv
// ----------------------------------------------------------------------------
// window_frame_time_stats
// sliding window statistics over tick intervals: mean, min, max, rank, fps
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | word
//  ---------+---------------------+-----------------------------------------
//  input    | i_valid / o_ready   | i_timestamp_us
//  output   | o_valid / i_ready   | count, mean, min, max, percentile, fps
//  config   | i_cfg_we            | i_cfg_data (percentile fraction)
//
//  a tick's sequence is set by the single window ram read port, where a read
//  goes through the address register r_rdidx and then the data register r_rd;
//  the port serves a min/max/sum pass and then a rank pass of one candidate
//  against every entry per candidate
//  the divider is shared by the mean and the fps quotient, one bit a cycle
//  reset is synchronous and active low; the window ram is not cleared
//  a new word is taken while the previous result still waits in the output
//  register; a stalled result only holds back the next result
//
`default_nettype none

module window_frame_time_stats #(
    parameter int WINDOW_DEPTH = wfts_pkg::DefaultDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_timestamp_us,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_sample_count,
    output logic [31:0]      o_mean_us,
    output logic [31:0]      o_min_us,
    output logic [31:0]      o_max_us,
    output logic [31:0]      o_percentile_us,
    output logic [27:0]      o_fps_x256
);
    import wfts_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    // window ram, one write port and one read port
    logic [31:0] r_mem [WINDOW_DEPTH];
    logic [31:0] r_rd;

    t_state      r_state;
    logic [16:0] r_frac;
    logic [31:0] r_last;
    logic        r_have;
    logic [AW-1:0] r_wpos;
    logic [CW-1:0] r_fill;

    logic [31:0] r_now;
    logic [AW-1:0] r_i;          // candidate index
    logic [AW-1:0] r_j;          // scan index
    logic [CW-1:0] r_issued;     // reads issued in current pass
    logic        r_rdv;          // read address valid
    logic        r_dv;           // read data valid
    logic [AW-1:0] r_rdidx;
    logic [41:0] r_sum;
    logic [31:0] r_lo, r_hi, r_cand, r_pct;
    logic [CW-1:0] r_below, r_upto, r_rank;
    logic        r_phase_cand;   // next read fetches the candidate
    logic        r_found;
    logic [31:0] r_mean;
    logic [27:0] r_fps;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_ocnt;
    logic [31:0] r_omean, r_olo, r_ohi, r_opct;
    logic [27:0] r_ofps;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic [31:0] w_ivl;
    logic [CW+16:0] w_rank_wide;
    logic [CW:0]    w_rank_raw;

    assign w_ivl       = i_timestamp_us - r_last;
    assign w_rank_wide = {{CW{1'b0}}, r_frac} * {{17{1'b0}}, r_fill};
    assign w_rank_raw  = w_rank_wide[CW+16:16];

    wfts_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign o_ready = (r_state == S_IDLE);

    // window write at accept, reads during the sequence
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && r_have)
            r_mem[r_wpos] <= w_ivl;
        r_rd <= r_mem[r_rdidx];
    end

    always_comb begin
        w_dreq.start = 1'b0;
        w_dreq.num   = '0;
        w_dreq.den   = '0;
        if (r_state == S_SCAN && r_rdv && !r_phase_cand &&
            r_issued == r_fill && r_j == AW'(0)) begin
            w_dreq.start = 1'b0;
        end
        if (r_state == S_MEAN && !w_drsp.busy && !w_drsp.done && r_found) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = {1'b0, r_sum};
            w_dreq.den   = {{(32-CW){1'b0}}, r_fill};
        end
        if (r_state == S_FPS && !w_drsp.busy && !w_drsp.done && r_found &&
            r_mean != '0) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = {15'd0, FpsNumerator};
            w_dreq.den   = r_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_frac   <= FracReset;
            r_last   <= '0;
            r_have   <= 1'b0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_rdv    <= 1'b0;
            r_dv     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_frac <= i_cfg_data;
            if (r_ovalid && i_ready && r_state != S_OUT)
                r_ovalid <= 1'b0;
            r_rdv <= 1'b0;
            r_dv  <= r_rdv;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last <= i_timestamp_us;
                        r_have <= 1'b1;
                        if (r_have) begin
                            r_wpos <= (r_wpos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                            if (r_fill != CW'(WINDOW_DEPTH))
                                r_fill <= r_fill + 1'b1;
                        end
                        r_sum    <= '0;
                        r_lo     <= '1;
                        r_hi     <= '0;
                        r_issued <= '0;
                        r_j      <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                // min, max and sum pass
                S_SCAN: begin
                    if (r_fill == '0) begin
                        r_mean  <= '0;
                        r_lo    <= '0;
                        r_pct   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (r_issued != r_fill) begin
                            r_rdidx  <= r_j;
                            r_rdv    <= 1'b1;
                            r_j      <= r_j + 1'b1;
                            r_issued <= r_issued + 1'b1;
                        end
                        if (r_dv) begin
                            r_sum <= r_sum + {10'd0, r_rd};
                            if (r_rd < r_lo) r_lo <= r_rd;
                            if (r_rd > r_hi) r_hi <= r_rd;
                        end
                        if (r_issued == r_fill && !r_rdv && !r_dv) begin
                            r_found <= 1'b1;
                            r_state <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_dreq.start)
                        r_found <= 1'b0;
                    if (w_drsp.done) begin
                        r_mean <= w_drsp.quo[31:0];
                        r_rank <= (w_rank_raw > {1'b0, r_fill - 1'b1}) ?
                                  r_fill - 1'b1 : w_rank_raw[CW-1:0];
                        r_i    <= '0;
                        r_phase_cand <= 1'b1;
                        r_issued <= '0;
                        r_state  <= S_RANK;
                    end
                end
                // per candidate: one read of the candidate, then count over all
                S_RANK: begin
                    if (r_phase_cand) begin
                        if (!r_rdv && r_issued == '0) begin
                            r_rdidx  <= r_i;
                            r_rdv    <= 1'b1;
                            r_issued <= CW'(1);
                        end else if (r_dv) begin
                            r_cand   <= r_rd;
                            r_below  <= '0;
                            r_upto   <= '0;
                            r_j      <= '0;
                            r_issued <= '0;
                            r_phase_cand <= 1'b0;
                        end
                    end else begin
                        if (r_issued != r_fill) begin
                            r_rdidx  <= r_j;
                            r_rdv    <= 1'b1;
                            r_j      <= r_j + 1'b1;
                            r_issued <= r_issued + 1'b1;
                        end
                        if (r_dv) begin
                            if (r_rd < r_cand)  r_below <= r_below + 1'b1;
                            if (r_rd <= r_cand) r_upto  <= r_upto + 1'b1;
                        end
                        if (r_issued == r_fill && !r_rdv && !r_dv) begin
                            if (r_below <= r_rank && r_rank < r_upto) begin
                                r_pct   <= r_cand;
                                r_found <= 1'b1;
                                r_state <= S_FPS;
                            end else begin
                                r_i      <= r_i + 1'b1;
                                r_issued <= '0;
                                r_phase_cand <= 1'b1;
                            end
                        end
                    end
                end
                S_FPS: begin
                    if (r_mean == '0) begin
                        r_found <= 1'b0;
                        r_fps   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (w_dreq.start)
                            r_found <= 1'b0;
                        if (w_drsp.done) begin
                            r_fps   <= w_drsp.quo[27:0];
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_ocnt   <= 8'(r_fill);
                        r_omean  <= r_mean;
                        r_olo    <= r_lo;
                        r_ohi    <= r_hi;
                        r_opct   <= r_pct;
                        r_ofps   <= (r_fill == '0) ? '0 : r_fps;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_sample_count  = r_ocnt;
    assign o_mean_us       = r_omean;
    assign o_min_us        = r_olo;
    assign o_max_us        = r_ohi;
    assign o_percentile_us = r_opct;
    assign o_fps_x256      = r_ofps;

endmodule

`default_nettype wire

FILE: rtl/wfts_checker.sv
// ----------------------------------------------------------------------------
// wfts_checker
// port level checks for the frame interval statistics block
// ----------------------------------------------------------------------------
`default_nettype none

module wfts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_sample_count,
    input wire logic [31:0] o_mean_us,
    input wire logic [31:0] o_min_us,
    input wire logic [31:0] o_max_us,
    input wire logic [31:0] o_percentile_us,
    input wire logic [27:0] o_fps_x256
);

    // valid, mean and percentile held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mean_us) && $stable(o_percentile_us))
        else $error("result changed while stalled");

    // not ready for a word in the cycle after one is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready straight after accept");

    // empty window gives zero mean, max and fps
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sample_count == 8'd0 |->
        o_mean_us == 32'd0 && o_max_us == 32'd0 && o_fps_x256 == 28'd0)
        else $error("non-zero statistic on empty window");

    // ordering of statistics
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_us <= o_percentile_us && o_percentile_us <= o_max_us &&
        o_min_us <= o_mean_us && o_mean_us <= o_max_us)
        else $error("statistics out of order");

endmodule

bind window_frame_time_stats wfts_checker u_wfts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sample_count (o_sample_count),
    .o_mean_us      (o_mean_us),
    .o_min_us       (o_min_us),
    .o_max_us       (o_max_us),
    .o_percentile_us(o_percentile_us),
    .o_fps_x256     (o_fps_x256)
);

`default_nettype wire

FILE: tb/wfts_checker.sv
// ----------------------------------------------------------------------------
// wfts_scoreboard
// watches the tick and result channels, predicts each result from a private
// copy of the window state and compares field by field
// ----------------------------------------------------------------------------
module wfts_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_timestamp_us,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_sample_count,
    input  logic [31:0] o_mean_us,
    input  logic [31:0] o_min_us,
    input  logic [31:0] o_max_us,
    input  logic [31:0] o_percentile_us,
    input  logic [27:0] o_fps_x256,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = wfts_pkg::DefaultDepth;

    typedef struct packed {
        logic [7:0]  cnt;
        logic [31:0] mean;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] pct;
        logic [27:0] fps;
    } t_stats;

    logic [16:0] frac;
    logic [31:0] prev_time;
    logic        seen_tick;
    logic [31:0] intervals [Depth];
    int          wr_idx;
    int          fill;
    t_stats      stats_q [$];

    function automatic t_stats tick_stats(input logic [31:0] now);
        t_stats s;
        logic [63:0] total;
        logic [63:0] rank_w;
        int rank;
        logic [31:0] sorted [$];
        total = 0;
        s = '0;
        if (seen_tick) begin
            intervals[wr_idx] = now - prev_time;
            wr_idx = (wr_idx + 1) % Depth;
            if (fill < Depth) fill++;
        end
        prev_time = now;
        seen_tick = 1'b1;
        s.cnt = fill[7:0];
        if (fill > 0) begin
            s.lo = intervals[0];
            s.hi = intervals[0];
            for (int i = 0; i < fill; i++) begin
                total += intervals[i];
                if (intervals[i] < s.lo) s.lo = intervals[i];
                if (intervals[i] > s.hi) s.hi = intervals[i];
                sorted.push_back(intervals[i]);
            end
            s.mean = total / fill;
            sorted.sort();
            rank_w = (64'(frac) * fill) >> wfts_pkg::FracShift;
            rank = (rank_w > fill - 1) ? fill - 1 : int'(rank_w);
            s.pct = sorted[rank];
            if (s.mean != 0) s.fps = 28'(32'd256000000 / s.mean);
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        if (!i_rst_n) begin
            frac <= wfts_pkg::FracReset;
            prev_time <= 0;
            seen_tick <= 0;
            wr_idx <= 0;
            fill <= 0;
            fail_count <= 0;
            results_seen <= 0;
            stats_q.delete();
            pending = 0;
        end else begin
            if (i_cfg_we) frac = i_cfg_data;
            if (i_valid && o_ready) stats_q.push_back(tick_stats(i_timestamp_us));
            if (o_valid && i_ready) begin
                got = {o_sample_count, o_mean_us, o_min_us, o_max_us,
                       o_percentile_us, o_fps_x256};
                results_seen <= results_seen + 1;
                if (stats_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = stats_q.pop_front();
                    if (got !== want) begin
                        // report each field that differs
                        if (got.cnt !== want.cnt)
                            $display("%0t: count exp %0d got %0d", $time, want.cnt, got.cnt);
                        if (got.mean !== want.mean)
                            $display("%0t: mean exp %0d got %0d", $time, want.mean, got.mean);
                        if (got.lo !== want.lo)
                            $display("%0t: min exp %0d got %0d", $time, want.lo, got.lo);
                        if (got.hi !== want.hi)
                            $display("%0t: max exp %0d got %0d", $time, want.hi, got.hi);
                        if (got.pct !== want.pct)
                            $display("%0t: pct exp %0d got %0d", $time, want.pct, got.pct);
                        if (got.fps !== want.fps)
                            $display("%0t: fps exp %0d got %0d", $time, want.fps, got.fps);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending = stats_q.size();
        end
    end
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the frame interval statistics block: directed ticks covering
// the empty window, zero and wrapping intervals and rank extremes, then
// random ticks under several fraction settings, with random stalls
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [31:0] i_timestamp_us = 0;
    logic        i_cfg_we = 0;
    logic [16:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [7:0]  o_sample_count;
    logic [31:0] o_mean_us, o_min_us, o_max_us, o_percentile_us;
    logic [27:0] o_fps_x256;
    int          fail_count, pending, results_seen;
    logic [31:0] now_us = 0;
    int          tick_total = 0;

    always #6 i_clk = ~i_clk;

    window_frame_time_stats dut (.*);
    wfts_scoreboard chk (.*);

    // random gap: mostly short, sometimes long
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    endfunction

    // result side stalls at random, with calm stretches
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
            i_ready <= (n == 0);
            repeat (n) @(negedge i_clk);
        end
    end

    // send one timestamp word, holding it until taken; valid stays high
    // on return so that a word can follow with no gap
    task automatic send_tick(input logic [31:0] ts);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1;
        i_timestamp_us <= ts;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        tick_total++;
    endtask

    // advance time by an interval and send
    task automatic step_by(input logic [31:0] dt);
        now_us = now_us + dt;
        send_tick(now_us);
    endtask

    // drain then write the fraction register while idle
    task automatic set_fraction(input logic [16:0] f);
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= f;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    initial begin
        logic [16:0] fracs [5];
        fracs = '{17'd0, 17'd65536, 17'd32768, 17'h1FFFF, 17'd62259};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty window, zero interval, extremes, backwards wrap
        send_tick(32'hFFFF_FFF0);
        now_us = 32'hFFFF_FFF0;
        step_by(0);
        step_by(32'hFFFF_FFFF);
        step_by(1);
        step_by(32'h8000_0000);
        send_tick(32'h0000_0010);  // timestamp going backwards
        now_us = 32'h10;
        step_by(32'h5555_5555);
        step_by(32'hAAAA_AAAA);
        step_by(16667);
        step_by(16667);
        set_fraction(17'd0);
        step_by(3);
        step_by(33333);
        set_fraction(17'd65536);
        step_by(7);
        step_by(16000);

        // random: keep growing the window under each fraction setting
        foreach (fracs[k]) begin
            set_fraction(fracs[k]);
            repeat (k == 4 ? 30 : 14) begin
                case ($urandom_range(0, 5))
                    0: step_by($urandom());
                    1: step_by($urandom_range(0, 4));
                    default: step_by($urandom_range(15000, 18000));
                endcase
            end
        end
        i_valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("ticks sent %0d, results checked %0d", tick_total, results_seen);
        $display("covered wrapping intervals, a window of about 100 entries, five fractions");
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #80ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
